// File: design/pbps_pkg.sv
// Package for the penalty bitmap path spray block: beat types, codes and constants.
package pbps_pkg;

    localparam int MAX_PATHS_DEF = 256;
    localparam int TABLE_LOG2    = 8;
    localparam int PEN_W         = 8;
    localparam int CNT_W         = 9;
    localparam int CFG_AW        = 4;
    localparam int CFG_DW        = 32;

    localparam logic [PEN_W-1:0] PEN_ECN       = 8'd1;
    localparam logic [PEN_W-1:0] PEN_NACK      = 8'd4;
    localparam logic [PEN_W-1:0] MAX_PEN_RESET = 8'd15;
    localparam logic [3:0]       LOG2_RESET    = 4'd8;
    localparam logic [15:0]      UPPER_RESET   = 16'd0;
    localparam logic [15:0]      SEED_RESET    = 16'd44257;
    localparam logic [15:0]      LFSR_TAPS     = 16'hB400;
    localparam logic [CNT_W-1:0] CNT_MAX       = 9'd256;

    typedef enum logic {
        KIND_FEEDBACK = 1'b0,
        KIND_REQUEST  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        FB_GOOD    = 2'd0,
        FB_ECN     = 2'd1,
        FB_NACK    = 2'd2,
        FB_TIMEOUT = 2'd3
    } t_fb;

    typedef enum logic [1:0] {
        REG_PATH_LOG2 = 2'd0,
        REG_MAX_PEN   = 2'd1,
        REG_UPPER     = 2'd2,
        REG_SEED      = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FB,
        S_PROBE,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [15:0] path_id;
        logic [1:0]  feedback;
    } t_in_beat;

    typedef struct packed {
        logic [15:0]      entropy;
        logic [CNT_W-1:0] penalized_count;
    } t_out_beat;

    typedef struct packed {
        logic [3:0]       path_count_log2;
        logic [PEN_W-1:0] max_penalty;
        logic [15:0]      upper_entropy_bits;
        logic             seed_load;
        logic [15:0]      seed;
    } t_cfg;

    // Largest usable log2 of the path count for a given path limit.
    function automatic int path_log2_limit(int max_paths);
        int l;
        l = $clog2(max_paths + 1) - 1;
        if (l > TABLE_LOG2) begin
            l = TABLE_LOG2;
        end
        return l;
    endfunction

    // Address width of the penalty table, at least one bit.
    function automatic int table_aw(int max_paths);
        int l;
        l = path_log2_limit(max_paths);
        return (l < 1) ? 1 : l;
    endfunction

endpackage

// File: design/penalty_bitmap_path_spray_top.sv
// Top level of the penalty bitmap path spray block.
//
//   channel   direction  handshake                  beat
//   in        input      i_in_valid / o_in_stall     kind, path_id, feedback
//   out       output     o_out_valid / i_out_stall   entropy, penalized_count
//   config    input      psel, penable, pwrite       paddr, pwdata, prdata
//
// A feedback beat reads the penalty table entry, then writes the updated penalty back.
// A request beat probes entries until it reads a zero penalty or its probe count exceeds
// the path count; each probe is one read of the table memory's single read port.
// Reset is synchronous and active low; the penalty table reads as zero after reset
// through per-entry valid bits, so no clearing pass is needed.
// The block works on one beat at a time and stalls its input while busy; a result
// waiting in the output register does not stall the input, and a finished request
// parks in a hold register until the output register frees up.
module penalty_bitmap_path_spray_top #(
    parameter int MAX_PATHS = pbps_pkg::MAX_PATHS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  pbps_pkg::t_in_beat          i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output pbps_pkg::t_out_beat         o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbps_pkg::CFG_AW-1:0] paddr,
    input  logic [pbps_pkg::CFG_DW-1:0] pwdata,
    output logic [pbps_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);

    // Table address width follows from the path limit.
    localparam int AW = pbps_pkg::table_aw(MAX_PATHS);

    pbps_pkg::t_cfg             cfg;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [pbps_pkg::PEN_W-1:0] rd_data;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [pbps_pkg::PEN_W-1:0] wr_data;

    // Register file for the four configuration registers.
    pbps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Penalty per path, one read and one write per cycle.
    pbps_pen_mem #(
        .AW (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Sequencer holding the spray index, scramble, LFSR and penalized-path count.
    pbps_ctrl #(
        .MAX_PATHS (MAX_PATHS),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

`ifndef SYNTHESIS
    // Every accepted beat keeps the block busy for at least the following cycle.
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted beat");

    // A result only appears at the end of work in progress.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in flight");

    // A feedback beat never produces a result.
    a_feedback_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_in.kind && !o_out_valid) |=> !o_out_valid)
        else $error("feedback beat produced a result");

    // The penalized-path count never exceeds its ceiling, CNT_MAX.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.penalized_count <= pbps_pkg::CNT_MAX))
        else $error("penalized-path count above its ceiling");
`endif

endmodule

// File: design/pbps_pen_mem.sv
// Penalty table memory: one write and one registered read port, with write bypass.
module pbps_pen_mem #(
    parameter int AW = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [pbps_pkg::PEN_W-1:0] o_rd_data,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [pbps_pkg::PEN_W-1:0] i_wr_data
);

    localparam int DEPTH = 1 << AW;

    logic [pbps_pkg::PEN_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    logic [pbps_pkg::PEN_W-1:0] r_q;
    logic                       r_q_vld;
    logic                       r_byp;
    logic [pbps_pkg::PEN_W-1:0] r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // Entries never written read as zero after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
            r_byp   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_vld[i_rd_addr];
                r_byp   <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : (r_q_vld ? r_q : '0);

endmodule

// File: design/pbps_cfg.sv
// Configuration registers behind the APB-style port.
module pbps_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbps_pkg::CFG_AW-1:0]  paddr,
    input  logic [pbps_pkg::CFG_DW-1:0]  pwdata,
    output logic [pbps_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready,
    output pbps_pkg::t_cfg               o_cfg
);

    logic [3:0]                 r_log2;
    logic [pbps_pkg::PEN_W-1:0] r_max_pen;
    logic [15:0]                r_upper;
    logic [15:0]                r_seed;
    logic                       wr;
    pbps_pkg::t_reg             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = pbps_pkg::t_reg'(paddr[3:2]);
    assign wr      = psel && penable && pwrite && (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2    <= pbps_pkg::LOG2_RESET;
            r_max_pen <= pbps_pkg::MAX_PEN_RESET;
            r_upper   <= pbps_pkg::UPPER_RESET;
            r_seed    <= pbps_pkg::SEED_RESET;
        end else if (wr) begin
            unique case (reg_sel)
                pbps_pkg::REG_PATH_LOG2: r_log2    <= pwdata[3:0];
                pbps_pkg::REG_MAX_PEN:   r_max_pen <= pwdata[7:0];
                pbps_pkg::REG_UPPER:     r_upper   <= pwdata[15:0];
                pbps_pkg::REG_SEED:      r_seed    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (reg_sel)
                pbps_pkg::REG_PATH_LOG2: prdata = {28'd0, r_log2};
                pbps_pkg::REG_MAX_PEN:   prdata = {24'd0, r_max_pen};
                pbps_pkg::REG_UPPER:     prdata = {16'd0, r_upper};
                pbps_pkg::REG_SEED:      prdata = {16'd0, r_seed};
                default:                 prdata = '0;
            endcase
        end
    end

    assign o_cfg.path_count_log2    = r_log2;
    assign o_cfg.max_penalty        = r_max_pen;
    assign o_cfg.upper_entropy_bits = r_upper;
    assign o_cfg.seed_load          = wr && (reg_sel == pbps_pkg::REG_SEED);
    assign o_cfg.seed               = pwdata[15:0];

endmodule

// File: design/pbps_ctrl.sv
// Sequencer: feedback read-modify-write and the request probe walk over the penalty table.
module pbps_ctrl #(
    parameter int MAX_PATHS = pbps_pkg::MAX_PATHS_DEF,
    parameter int AW        = pbps_pkg::table_aw(MAX_PATHS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pbps_pkg::t_cfg             i_cfg,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pbps_pkg::t_in_beat         i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pbps_pkg::t_out_beat        o_out,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    input  logic [pbps_pkg::PEN_W-1:0] i_rd_data,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output logic [pbps_pkg::PEN_W-1:0] o_wr_data
);

    localparam int          LIM   = pbps_pkg::path_log2_limit(MAX_PATHS);
    localparam logic [3:0]  LIM_L = 4'(LIM);

    pbps_pkg::t_state           r_state, n_state;
    logic [AW-1:0]              r_idx, n_idx;
    logic [AW-1:0]              r_scr, n_scr;
    logic [15:0]                r_lfsr, n_lfsr;
    logic [pbps_pkg::CNT_W-1:0] r_count, n_count;
    logic [AW-1:0]              r_e, n_e;
    logic                       r_first, n_first;
    logic [AW:0]                r_probes, n_probes;
    logic [1:0]                 r_fb, n_fb;
    logic                       r_out_valid, n_out_valid;
    pbps_pkg::t_out_beat        r_out, n_out;
    pbps_pkg::t_out_beat        r_hold, n_hold;

    logic [3:0]                 eff_log2;
    logic [AW:0]                paths;
    logic [AW-1:0]              mask;
    logic [AW:0]                idx_inc;
    logic [15:0]                lfsr_step;
    logic [AW-1:0]              adv_idx, adv_scr, adv_e;
    logic [15:0]                adv_lfsr;
    logic [AW+1:0]              probes_inc;
    logic [pbps_pkg::PEN_W-1:0] add;
    logic [pbps_pkg::PEN_W:0]   sum;
    logic [pbps_pkg::PEN_W-1:0] sum_sat;
    logic                       last;
    logic                       out_free;
    logic [15:0]                seed_eff;
    pbps_pkg::t_out_beat        res;

    // Path count, mask and one step of the index walk.
    always_comb begin
        eff_log2  = (i_cfg.path_count_log2 > LIM_L) ? LIM_L : i_cfg.path_count_log2;
        paths     = (AW+1)'(1) << eff_log2;
        mask      = AW'(paths - (AW+1)'(1));
        idx_inc   = {1'b0, r_idx} + (AW+1)'(1);
        lfsr_step = r_lfsr[0] ? ((r_lfsr >> 1) ^ pbps_pkg::LFSR_TAPS) : (r_lfsr >> 1);
        if (idx_inc >= paths) begin
            adv_idx  = '0;
            adv_lfsr = lfsr_step;
            adv_scr  = lfsr_step[AW-1:0] & mask;
        end else begin
            adv_idx  = idx_inc[AW-1:0];
            adv_lfsr = r_lfsr;
            adv_scr  = r_scr;
        end
        adv_e      = (adv_idx ^ adv_scr) & mask;
        probes_inc = {1'b0, r_probes} + (AW+2)'(1);
        seed_eff   = (i_cfg.seed == 16'd0) ? 16'd1 : i_cfg.seed;
    end

    // Feedback penalty with saturation.
    always_comb begin
        unique case (pbps_pkg::t_fb'(r_fb))
            pbps_pkg::FB_GOOD:    add = '0;
            pbps_pkg::FB_ECN:     add = pbps_pkg::PEN_ECN;
            pbps_pkg::FB_NACK:    add = pbps_pkg::PEN_NACK;
            pbps_pkg::FB_TIMEOUT: add = i_cfg.max_penalty;
            default:              add = '0;
        endcase
        sum     = {1'b0, i_rd_data} + {1'b0, add};
        sum_sat = (sum > {1'b0, i_cfg.max_penalty}) ? i_cfg.max_penalty : sum[pbps_pkg::PEN_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_scr       = r_scr;
        n_lfsr      = r_lfsr;
        n_count     = r_count;
        n_e         = r_e;
        n_first     = r_first;
        n_probes    = r_probes;
        n_fb        = r_fb;
        n_out       = r_out;
        n_hold      = r_hold;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_e;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_e;
        o_wr_data   = i_rd_data;
        last        = 1'b0;
        res         = r_hold;
        out_free    = !r_out_valid || !i_out_stall;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            pbps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_rd_en = 1'b1;
                    if (pbps_pkg::t_kind'(i_in.kind) == pbps_pkg::KIND_REQUEST) begin
                        o_rd_addr = (r_idx ^ r_scr) & mask;
                        n_state   = pbps_pkg::S_PROBE;
                    end else begin
                        o_rd_addr = i_in.path_id[AW-1:0] & mask;
                        n_state   = pbps_pkg::S_FB;
                    end
                    n_e      = o_rd_addr;
                    n_first  = 1'b1;
                    n_probes = '0;
                    n_fb     = i_in.feedback;
                end
                if (i_cfg.seed_load) begin
                    n_lfsr = seed_eff;
                    n_scr  = seed_eff[AW-1:0];
                end
            end
            pbps_pkg::S_FB: begin
                o_wr_en   = 1'b1;
                o_wr_data = sum_sat;
                if (i_rd_data == '0 && sum_sat != '0 && r_count != pbps_pkg::CNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
                n_state = pbps_pkg::S_IDLE;
            end
            pbps_pkg::S_PROBE: begin
                last = (i_rd_data == '0) || (probes_inc > {1'b0, paths});
                // Only the first penalized entry of the walk loses a point.
                if (i_rd_data != '0 && r_first) begin
                    o_wr_en   = 1'b1;
                    o_wr_data = i_rd_data - 1'b1;
                    n_first   = 1'b0;
                    if (i_rd_data == 8'd1 && r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end
                n_idx  = adv_idx;
                n_scr  = adv_scr;
                n_lfsr = adv_lfsr;
                if (!last) begin
                    n_probes  = probes_inc[AW:0];
                    o_rd_en   = 1'b1;
                    o_rd_addr = adv_e;
                    n_e       = adv_e;
                end else begin
                    res.entropy         = 16'(r_e) | (i_cfg.upper_entropy_bits & ~16'(mask));
                    res.penalized_count = n_count;
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = res;
                        n_state     = pbps_pkg::S_IDLE;
                    end else begin
                        n_hold  = res;
                        n_state = pbps_pkg::S_HOLD;
                    end
                end
            end
            pbps_pkg::S_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_hold;
                    n_state     = pbps_pkg::S_IDLE;
                end
            end
            default: n_state = pbps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbps_pkg::S_IDLE;
            r_idx       <= '0;
            r_scr       <= pbps_pkg::SEED_RESET[AW-1:0];
            r_lfsr      <= pbps_pkg::SEED_RESET;
            r_count     <= '0;
            r_first     <= 1'b0;
            r_probes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_scr       <= n_scr;
            r_lfsr      <= n_lfsr;
            r_count     <= n_count;
            r_first     <= n_first;
            r_probes    <= n_probes;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_fb   <= n_fb;
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign o_in_stall  = (r_state != pbps_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
